FILE: design/detc_pkg.sv
package detc_pkg;

    localparam int VTX_W     = 11;
    localparam int IDX_W     = 10;
    localparam int CNT_OUT_W = 11;
    localparam int ENTRY_W   = 4 * VTX_W;

    typedef logic [1:0] t_op;
    localparam t_op OP_CLEAR  = 2'd0;
    localparam t_op OP_APPEND = 2'd1;
    localparam t_op OP_QUERY  = 2'd2;

    typedef logic [1:0] t_status;
    localparam t_status STS_OK    = 2'd0;
    localparam t_status STS_FULL  = 2'd1;
    localparam t_status STS_RANGE = 2'd2;

    typedef struct packed {
        logic [VTX_W-1:0] lf;
        logic [VTX_W-1:0] ls;
        logic [VTX_W-1:0] rf;
        logic [VTX_W-1:0] rs;
    } t_entry;

    // one endpoint pair: left vertex and right vertex
    typedef struct packed {
        logic [VTX_W-1:0] l;
        logic [VTX_W-1:0] r;
    } t_end;

    typedef struct packed {
        t_end apex;
        t_end far_end;
    } t_probe;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD_J,
        S_LATCH,
        S_SCAN
    } t_state;

endpackage

FILE: design/detc_ram.sv
module detc_ram #(
    parameter int WIDTH = 44,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: design/detc_match.sv
module detc_match (
    input  detc_pkg::t_probe i_probe,
    input  detc_pkg::t_entry i_entry,
    output logic             o_hit
);

    logic fwd_hit;
    logic rev_hit;

    // entry runs apex -> far_end on its first -> second endpoints
    assign fwd_hit = (i_entry.lf == i_probe.apex.l) && (i_entry.rf == i_probe.apex.r) &&
                     (i_entry.ls == i_probe.far_end.l) && (i_entry.rs == i_probe.far_end.r);
    // or the other way round
    assign rev_hit = (i_entry.ls == i_probe.apex.l) && (i_entry.rs == i_probe.apex.r) &&
                     (i_entry.lf == i_probe.far_end.l) && (i_entry.rf == i_probe.far_end.r);

    assign o_hit = fwd_hit || rev_hit;

endmodule

FILE: design/double_edge_triangle_check.sv
// Table of matched edge pairs with a triangle query. Clear and append words
// finish in the cycle after they are accepted: the result strobe o_valid
// follows the accepting edge and a new word may start in that same cycle. A
// query with an index at or beyond the stored count also returns in the cycle
// after it is accepted, with status 2. A valid query reads entries i and j and
// then scans the table through the single read port of the table memory, one
// entry per cycle, with one match unit: one scan if only the first or only the
// second endpoints are shared, two if both are, none if neither. A query holds
// busy until its scans end and stops early on the first match.
// Results cannot be held off by the receiver: o_found, o_status and
// o_stored_count are valid for the single cycle in which o_valid is high.
module double_edge_triangle_check #(
    parameter int TABLE_ENTRIES = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    input  detc_pkg::t_op                     i_op,
    input  logic [detc_pkg::VTX_W-1:0]        i_left_first,
    input  logic [detc_pkg::VTX_W-1:0]        i_left_second,
    input  logic [detc_pkg::VTX_W-1:0]        i_right_first,
    input  logic [detc_pkg::VTX_W-1:0]        i_right_second,
    input  logic [detc_pkg::IDX_W-1:0]        i_first_index,
    input  logic [detc_pkg::IDX_W-1:0]        i_second_index,
    output logic                              busy,
    output logic                              o_valid,
    output logic                              o_found,
    output detc_pkg::t_status                 o_status,
    output logic [detc_pkg::CNT_OUT_W-1:0]    o_stored_count
);

    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int ADDR_W = $clog2(TABLE_ENTRIES);
    localparam int EXT_W  = (CNT_W > detc_pkg::CNT_OUT_W) ? CNT_W : detc_pkg::CNT_OUT_W;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_ENTRIES);

    detc_pkg::t_state  r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_k, n_k;
    logic              r_vld, n_vld;
    logic              r_pass, n_pass;
    logic              r_share2, n_share2;
    detc_pkg::t_entry  r_ei, n_ei;
    detc_pkg::t_entry  r_ej, n_ej;
    logic [ADDR_W-1:0] r_j_addr, n_j_addr;
    logic              r_valid, n_valid;
    logic              r_found, n_found;
    detc_pkg::t_status r_status, n_status;

    logic                          wr_en;
    logic [ADDR_W-1:0]             wr_addr;
    detc_pkg::t_entry              wr_entry;
    logic                          rd_en;
    logic [ADDR_W-1:0]             rd_addr;
    logic [detc_pkg::ENTRY_W-1:0]  rd_data;
    detc_pkg::t_entry              rd_entry;

    logic             accept;
    logic [EXT_W-1:0] count_ext;
    logic [EXT_W-1:0] i_ext;
    logic [EXT_W-1:0] j_ext;
    logic             idx_ok;
    logic             is_full;
    logic             share1;
    logic             share2;
    logic             more;
    logic             hit;
    logic             pass_end;
    detc_pkg::t_probe probe;

    assign accept    = start && !busy;
    assign count_ext = EXT_W'(r_count);
    assign i_ext     = EXT_W'(i_first_index);
    assign j_ext     = EXT_W'(i_second_index);
    assign idx_ok    = (i_ext < count_ext) && (j_ext < count_ext);
    assign is_full   = (r_count == FULL_COUNT);
    assign rd_entry  = detc_pkg::t_entry'(rd_data);

    // rd_entry holds entry j here, r_ei holds entry i
    assign share1 = (rd_entry.lf == r_ei.lf) && (rd_entry.rf == r_ei.rf);
    assign share2 = (rd_entry.ls == r_ei.ls) && (rd_entry.rs == r_ei.rs);

    assign more     = (r_k < r_count);
    assign pass_end = r_vld && !hit && !more;

    assign wr_addr  = r_count[ADDR_W-1:0];
    assign wr_entry = '{lf: i_left_first, ls: i_left_second,
                        rf: i_right_first, rs: i_right_second};

    always_comb begin
        if (!r_pass) begin
            probe.apex    = '{l: r_ei.ls, r: r_ei.rs};
            probe.far_end = '{l: r_ej.ls, r: r_ej.rs};
        end else begin
            probe.apex    = '{l: r_ei.lf, r: r_ei.rf};
            probe.far_end = '{l: r_ej.lf, r: r_ej.rf};
        end
    end

    detc_match u_match (
        .i_probe (probe),
        .i_entry (rd_entry),
        .o_hit   (hit)
    );

    detc_ram #(
        .WIDTH (detc_pkg::ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_entry),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            detc_pkg::S_IDLE: begin
                if (accept && (i_op == detc_pkg::OP_QUERY) && idx_ok) begin
                    n_state = detc_pkg::S_RD_J;
                end
            end
            detc_pkg::S_RD_J: begin
                n_state = detc_pkg::S_LATCH;
            end
            detc_pkg::S_LATCH: begin
                if (share1 || share2) begin
                    n_state = detc_pkg::S_SCAN;
                end else begin
                    n_state = detc_pkg::S_IDLE;
                end
            end
            detc_pkg::S_SCAN: begin
                if (r_vld && hit) begin
                    n_state = detc_pkg::S_IDLE;
                end else if (pass_end && !(!r_pass && r_share2)) begin
                    n_state = detc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = detc_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_count  = r_count;
        n_k      = r_k;
        n_vld    = r_vld;
        n_pass   = r_pass;
        n_share2 = r_share2;
        n_ei     = r_ei;
        n_ej     = r_ej;
        n_j_addr = r_j_addr;
        n_valid  = 1'b0;
        n_found  = r_found;
        n_status = r_status;
        wr_en    = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = '0;
        unique case (r_state)
            detc_pkg::S_IDLE: begin
                if (accept) begin
                    n_valid  = 1'b1;
                    n_found  = 1'b0;
                    n_status = detc_pkg::STS_OK;
                    unique case (i_op)
                        detc_pkg::OP_CLEAR: begin
                            n_count = '0;
                        end
                        detc_pkg::OP_APPEND: begin
                            if (is_full) begin
                                n_status = detc_pkg::STS_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        detc_pkg::OP_QUERY: begin
                            if (!idx_ok) begin
                                n_status = detc_pkg::STS_RANGE;
                            end else begin
                                // hold the result until the scan ends
                                n_valid  = 1'b0;
                                rd_en    = 1'b1;
                                rd_addr  = i_ext[ADDR_W-1:0];
                                n_j_addr = j_ext[ADDR_W-1:0];
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            detc_pkg::S_RD_J: begin
                rd_en   = 1'b1;
                rd_addr = r_j_addr;
                n_ei    = rd_entry;
            end
            detc_pkg::S_LATCH: begin
                n_ej     = rd_entry;
                n_share2 = share2;
                n_pass   = !share1;
                n_k      = '0;
                n_vld    = 1'b0;
                if (!(share1 || share2)) begin
                    n_valid = 1'b1;
                end
            end
            detc_pkg::S_SCAN: begin
                if (more && !(r_vld && hit)) begin
                    rd_en   = 1'b1;
                    rd_addr = r_k[ADDR_W-1:0];
                    n_k     = r_k + 1'b1;
                    n_vld   = 1'b1;
                end else begin
                    n_vld   = 1'b0;
                end
                if (r_vld && hit) begin
                    n_valid = 1'b1;
                    n_found = 1'b1;
                end else if (pass_end) begin
                    if (!r_pass && r_share2) begin
                        // rescan with the second endpoints as the shared apex
                        n_pass = 1'b1;
                        n_k    = '0;
                    end else begin
                        n_valid = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= detc_pkg::S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
            r_vld   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
            r_vld   <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k      <= n_k;
        r_pass   <= n_pass;
        r_share2 <= n_share2;
        r_ei     <= n_ei;
        r_ej     <= n_ej;
        r_j_addr <= n_j_addr;
        r_found  <= n_found;
        r_status <= n_status;
    end

    assign busy           = (r_state != detc_pkg::S_IDLE);
    assign o_valid        = r_valid;
    assign o_found        = r_found;
    assign o_status       = r_status;
    assign o_stored_count = count_ext[detc_pkg::CNT_OUT_W-1:0];

endmodule

FILE: design/detc_checker.sv
module detc_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           start,
    input logic                           busy,
    input detc_pkg::t_op                  i_op,
    input logic                           o_valid,
    input logic                           o_found,
    input detc_pkg::t_status              o_status,
    input logic [detc_pkg::CNT_OUT_W-1:0] o_stored_count
);

    // a result word never shows while a query is still scanning
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result word while busy");

    // only a clean query can report a triangle
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |-> (o_status == detc_pkg::STS_OK))
        else $error("found with error status");

    // a clear answers in the next cycle with an empty table
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_op == detc_pkg::OP_CLEAR))
            |=> (o_valid && (o_stored_count == '0)))
        else $error("clear not answered with empty table");

    // only an accepted query word makes the block busy
    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> ($past(start) && ($past(i_op) == detc_pkg::OP_QUERY)))
        else $error("busy without a query word");

    // the table count does not move while a query scans
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && $past(busy)) |-> $stable(o_stored_count))
        else $error("count moved during a query");

endmodule

bind double_edge_triangle_check detc_checker u_detc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_op           (i_op),
    .o_valid        (o_valid),
    .o_found        (o_found),
    .o_status       (o_status),
    .o_stored_count (o_stored_count)
);
